### rtl/gnss_pm_pkg.sv
// Shared types and constants for the receiver power-mode controller.
`default_nettype none
package gnss_pm_pkg;

  typedef enum logic [1:0] {
    MODE_BACKUP = 2'd0,
    MODE_ACQ    = 2'd1,
    MODE_FULL   = 2'd2,
    MODE_LOW    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ACT_NONE      = 3'd0,
    ACT_WAKE      = 3'd1,
    ACT_STANDBY   = 3'd2,
    ACT_LOW       = 3'd3,
    ACT_FULL      = 3'd4,
    ACT_RESET     = 3'd5,
    ACT_CONFIGURE = 3'd6
  } act_t;

  typedef enum logic [1:0] {
    EV_USE   = 2'd0,
    EV_EPOCH = 2'd1,
    EV_TICK  = 2'd2,
    EV_NOP   = 2'd3
  } event_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned LIMIT_W    = 24;
  localparam int unsigned DUR_W      = 16;
  localparam int unsigned COUNT_W    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_POWER_AVAIL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOOD_SIGNAL_MS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEAK_EPOCH_LIM  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE_LIM_MS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LIM_MS    = 3'd4;

  localparam logic               RST_LOW_POWER_AVAIL = 1'b1;
  localparam logic [LIMIT_W-1:0] RST_GOOD_SIGNAL_MS  = 24'd10000;
  localparam logic [COUNT_W-1:0] RST_WEAK_EPOCH_LIM  = 8'd3;
  localparam logic [LIMIT_W-1:0] RST_SILENCE_LIM_MS  = 24'd5000;
  localparam logic [LIMIT_W-1:0] RST_RESET_LIM_MS    = 24'd30000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 8'hFF;

endpackage
`default_nettype wire

### rtl/gnss_receiver_power_mode_fsm_core.sv
// A result appears in the output register in the cycle after its request is accepted.
// Throughput: one request per cycle while in_stall is low; the whole state update is a
// combinational pass from the current state registers into the next state and the result register.
// in_stall rises only while a result is held and the result side stalls.
// Reset (rst_n low, synchronous): backup mode, counters cleared, no result pending,
// configuration registers back to their power-on values.
`default_nettype none
module gnss_receiver_power_mode_fsm_core
  import gnss_pm_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request channel
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_action,
  input  wire logic                  in_uses_receiver,
  input  wire logic                  in_has_fix,
  input  wire logic [DUR_W-1:0]      in_duration_ms,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [2:0]                 out_action_code,
  output logic [1:0]                 out_power_mode,
  // configuration writes
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [TIME_WIDTH-1:0] TIME_MAX = {TIME_WIDTH{1'b1}};

  // configuration
  logic               low_power_avail_r;
  logic [LIMIT_W-1:0] good_signal_ms_r;
  logic [COUNT_W-1:0] weak_epoch_limit_r;
  logic [LIMIT_W-1:0] silence_limit_ms_r;
  logic [LIMIT_W-1:0] reset_limit_ms_r;

  // controller state
  mode_t                 mode_r, mode_nxt;
  logic                  started_r, started_nxt;
  logic                  full_power_r, full_power_nxt;
  logic [COUNT_W-1:0]    no_fix_cnt_r, no_fix_cnt_nxt;
  logic [TIME_WIDTH-1:0] good_time_r, good_time_nxt;
  logic [TIME_WIDTH-1:0] silence_time_r, silence_time_nxt;
  act_t                  act_nxt;

  // result register
  logic  out_valid_r;
  act_t  out_act_r;
  mode_t out_mode_r;

  logic                  in_accept;
  logic [TIME_WIDTH-1:0] dur_ext;
  logic [TIME_WIDTH:0]   good_sum;
  logic [TIME_WIDTH:0]   silence_sum;
  logic [TIME_WIDTH-1:0] good_sat;
  logic [TIME_WIDTH-1:0] silence_sat;
  logic [COUNT_W-1:0]    no_fix_inc;
  logic [TIME_WIDTH-1:0] good_lim_ext;
  logic [TIME_WIDTH-1:0] silence_lim_ext;
  logic [TIME_WIDTH-1:0] reset_lim_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign dur_ext         = TIME_WIDTH'(in_duration_ms);
  assign good_lim_ext    = TIME_WIDTH'(good_signal_ms_r);
  assign silence_lim_ext = TIME_WIDTH'(silence_limit_ms_r);
  assign reset_lim_ext   = TIME_WIDTH'(reset_limit_ms_r);

  // saturating accumulators
  assign good_sum    = {1'b0, good_time_r} + {1'b0, dur_ext};
  assign silence_sum = {1'b0, silence_time_r} + {1'b0, dur_ext};
  assign good_sat    = good_sum[TIME_WIDTH] ? TIME_MAX : good_sum[TIME_WIDTH-1:0];
  assign silence_sat = silence_sum[TIME_WIDTH] ? TIME_MAX : silence_sum[TIME_WIDTH-1:0];
  assign no_fix_inc  = (no_fix_cnt_r != COUNT_MAX) ? no_fix_cnt_r + 1'b1 : no_fix_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_power_avail_r  <= RST_LOW_POWER_AVAIL;
      good_signal_ms_r   <= RST_GOOD_SIGNAL_MS;
      weak_epoch_limit_r <= RST_WEAK_EPOCH_LIM;
      silence_limit_ms_r <= RST_SILENCE_LIM_MS;
      reset_limit_ms_r   <= RST_RESET_LIM_MS;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LOW_POWER_AVAIL: low_power_avail_r  <= cfg_data[0];
        REG_GOOD_SIGNAL_MS:  good_signal_ms_r   <= cfg_data;
        REG_WEAK_EPOCH_LIM:  weak_epoch_limit_r <= cfg_data[COUNT_W-1:0];
        REG_SILENCE_LIM_MS:  silence_limit_ms_r <= cfg_data;
        REG_RESET_LIM_MS:    reset_limit_ms_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_nxt         = mode_r;
    started_nxt      = started_r;
    full_power_nxt   = full_power_r;
    no_fix_cnt_nxt   = no_fix_cnt_r;
    good_time_nxt    = good_time_r;
    silence_time_nxt = silence_time_r;
    act_nxt          = ACT_NONE;
    case (event_t'(in_action))
      EV_USE: begin
        started_nxt = 1'b1;
        if (in_uses_receiver) begin
          if (mode_r == MODE_BACKUP) begin
            mode_nxt         = MODE_ACQ;
            full_power_nxt   = ~low_power_avail_r;
            no_fix_cnt_nxt   = '0;
            good_time_nxt    = '0;
            silence_time_nxt = '0;
            act_nxt          = ACT_WAKE;
          end
        end else if (mode_r != MODE_BACKUP || !started_r) begin
          // first use change after reset always reports standby
          mode_nxt = MODE_BACKUP;
          act_nxt  = ACT_STANDBY;
        end
      end
      EV_EPOCH: begin
        if (mode_r != MODE_BACKUP) begin
          silence_time_nxt = '0;
          if (in_has_fix) begin
            no_fix_cnt_nxt = '0;
            if (full_power_r && low_power_avail_r) begin
              if (good_sat >= good_lim_ext) begin
                full_power_nxt = 1'b0;
                good_time_nxt  = '0;
                act_nxt        = ACT_LOW;
              end else begin
                good_time_nxt = good_sat;
              end
            end
            mode_nxt = full_power_nxt ? MODE_FULL : MODE_LOW;
          end else begin
            good_time_nxt  = '0;
            no_fix_cnt_nxt = no_fix_inc;
            if (no_fix_inc >= weak_epoch_limit_r) begin
              mode_nxt = MODE_ACQ;
              if (!full_power_r) begin
                full_power_nxt = 1'b1;
                act_nxt        = ACT_FULL;
              end
            end
          end
        end
      end
      EV_TICK: begin
        if (mode_r != MODE_BACKUP) begin
          silence_time_nxt = silence_sat;
          // a threshold fires only on the tick that crosses it
          if (silence_time_r < reset_lim_ext && silence_sat >= reset_lim_ext) begin
            silence_time_nxt = '0;
            act_nxt          = ACT_RESET;
          end else if (silence_time_r < silence_lim_ext && silence_sat >= silence_lim_ext) begin
            act_nxt = ACT_CONFIGURE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_BACKUP;
      started_r      <= 1'b0;
      full_power_r   <= 1'b0;
      no_fix_cnt_r   <= '0;
      good_time_r    <= '0;
      silence_time_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_accept) begin
        mode_r         <= mode_nxt;
        started_r      <= started_nxt;
        full_power_r   <= full_power_nxt;
        no_fix_cnt_r   <= no_fix_cnt_nxt;
        good_time_r    <= good_time_nxt;
        silence_time_r <= silence_time_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_act_r  <= act_nxt;
      out_mode_r <= mode_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action_code = 3'(out_act_r);
  assign out_power_mode  = 2'(out_mode_r);

endmodule
`default_nettype wire

### rtl/gnss_pm_checker.sv
// Port-level checks for the power-mode controller, bound to the controller core.
`default_nettype none
module gnss_pm_checker
  import gnss_pm_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_action_code,
  input wire logic [1:0] out_power_mode
);

  // a held result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action_code)
      && $stable(out_power_mode))
    else $error("stalled result changed");

  // no request taken while the result register is blocked
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("request side open while result blocked");

  a_wake_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action_code == ACT_WAKE |-> out_power_mode == MODE_ACQ)
    else $error("wake without acquire mode");

  a_standby_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action_code == ACT_STANDBY |-> out_power_mode == MODE_BACKUP)
    else $error("standby without backup mode");

  a_power_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action_code == ACT_LOW || out_action_code == ACT_FULL) |->
      (out_action_code == ACT_LOW && out_power_mode == MODE_LOW) ||
      (out_action_code == ACT_FULL && out_power_mode == MODE_ACQ))
    else $error("power switch reported with wrong mode");

endmodule

bind gnss_receiver_power_mode_fsm_core gnss_pm_checker u_gnss_pm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_action_code (out_action_code),
  .out_power_mode  (out_power_mode)
);
`default_nettype wire
